>>> rtl/icsu_pkg.sv
// shared types and constants of the 3x3 saturating convolution unit
`default_nettype none

package icsu_pkg;

    // fixed field widths
    localparam int PIX_W       = 8;
    localparam int NUM_CH      = 4;
    localparam int OP_W        = 1;
    localparam int WIDTH_W     = 11;
    localparam int DIM_W       = 13;
    localparam int CHAN_W      = 3;
    localparam int COEF_W      = 48;
    localparam int TAP_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    // kernel geometry
    localparam int KERNEL_SIZE = 3;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;

    // arithmetic widths
    localparam int PROD_W      = 25;
    localparam int RSUM_W      = 27;
    localparam int SUM_W       = 29;

    // defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_CHANNELS_DEF = 4;

    localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

    // result queue
    localparam int FIFO_DEPTH  = 8;
    localparam int FPTR_W      = 3;
    localparam int FCNT_W      = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_PIXEL = 1'b0;
    localparam logic [OP_W-1:0] OP_DRAIN = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_CHANNEL_COUNT   = 3'd2,
        REG_COEF_ROW_TOP    = 3'd3,
        REG_COEF_ROW_MID    = 3'd4,
        REG_COEF_ROW_BOTTOM = 3'd5
    } cfg_reg_t;

    // register reset values, identity kernel
    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH   = 11'd1024;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT  = 13'd768;
    localparam logic [CHAN_W-1:0]  RST_CHANNEL_COUNT = 3'd4;
    localparam logic [COEF_W-1:0]  RST_COEF_TOP      = 48'h0000_0000_0000;
    localparam logic [COEF_W-1:0]  RST_COEF_MID      = 48'h0000_0100_0000;
    localparam logic [COEF_W-1:0]  RST_COEF_BOTTOM   = 48'h0000_0000_0000;

endpackage

`default_nettype wire

>>> rtl/icsu_if.sv
// stream and register-write interfaces of the convolution unit
`default_nettype none

interface icsu_pix_if;
    logic                              valid;
    logic                              ready;
    logic [icsu_pkg::OP_W-1:0]         operation;
    logic [icsu_pkg::PIX_W-1:0]        in_ch0;
    logic [icsu_pkg::PIX_W-1:0]        in_ch1;
    logic [icsu_pkg::PIX_W-1:0]        in_ch2;
    logic [icsu_pkg::PIX_W-1:0]        in_ch3;

    modport source (output valid, operation, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
    modport sink   (input valid, operation, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

interface icsu_res_if;
    logic                              valid;
    logic                              ready;
    logic [icsu_pkg::PIX_W-1:0]        out_ch0;
    logic [icsu_pkg::PIX_W-1:0]        out_ch1;
    logic [icsu_pkg::PIX_W-1:0]        out_ch2;
    logic [icsu_pkg::PIX_W-1:0]        out_ch3;
    logic                              was_filtered;
    logic                              frame_last;

    modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, was_filtered,
                    frame_last, input ready);
    modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3, was_filtered,
                    frame_last, output ready);
endinterface

interface icsu_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [icsu_pkg::CFG_IDX_W-1:0]    index;
    logic [icsu_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/image_convolution_3x3_saturating_unit.sv
// top level of the streaming 3x3 saturating convolution unit
// usage:
// - pixel channel: raster-order pixels, operation selects data pixel or drain tick;
//   after the last pixel of a frame, one row plus one pixel of drain ticks flush the tail
// - result channel: one result per pixel, one row plus one pixel behind the input;
//   was_filtered marks interior pixels, frame_last marks the final pixel of the frame
// - cfg channel: register writes (index, data), always ready; they are to be written only
//   while idle, which the user must ensure, as the block does not enforce it
// throughput: one pixel per cycle while ready; each line store has one read and one write
//   port, so every item costs one read and one write per store in consecutive cycles
// last window pixel to result: line-store read, window update, multiply, row sums, queue
// stall: an eight-entry result queue sits behind the datapath; ready drops when queued
//   plus in-flight results fill it, so no result is ever lost while the receiver
//   holds off and input keeps flowing while it takes results
// reset: counters, window and queue clear at once; line stores need no clearing,
//   their stale contents never reach a result; registers return to identity kernel,
//   1024 x 768, four channels
`default_nettype none

module image_convolution_3x3_saturating_unit #(
    parameter int MAX_WIDTH    = icsu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = icsu_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    icsu_pix_if.sink       pixel,
    icsu_res_if.source     result,
    icsu_cfg_if.sink       cfg
);

    localparam int PIX_W    = icsu_pkg::PIX_W;
    localparam int NUM_CH   = icsu_pkg::NUM_CH;
    localparam int DIM_W    = icsu_pkg::DIM_W;
    localparam int CHAN_W   = icsu_pkg::CHAN_W;
    localparam int TAP_W    = icsu_pkg::TAP_W;
    localparam int TAPS     = icsu_pkg::TAPS;
    localparam int KSIZE    = icsu_pkg::KERNEL_SIZE;
    localparam int PROD_W   = icsu_pkg::PROD_W;
    localparam int RSUM_W   = icsu_pkg::RSUM_W;
    localparam int SUM_W    = icsu_pkg::SUM_W;
    localparam int FDEPTH   = icsu_pkg::FIFO_DEPTH;
    localparam int FPTR_W   = icsu_pkg::FPTR_W;
    localparam int FCNT_W   = icsu_pkg::FCNT_W;

    localparam int SW       = PIX_W * MAX_CHANNELS;     // line store word
    localparam int CW       = $clog2(MAX_WIDTH);        // column counter / store address
    localparam int WW       = $clog2(MAX_WIDTH + 1);    // effective width
    localparam int CNT_W    = WW + 1;                   // column compare width
    localparam int ROWX_W   = DIM_W + 1;                // row compare width

    // one queued result
    typedef struct packed {
        logic [NUM_CH-1:0][PIX_W-1:0] ch;
        logic                         filtered;
        logic                         last;
    } res_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [icsu_pkg::WIDTH_W-1:0]  width_reg;
    logic [DIM_W-1:0]              height_reg;
    logic [CHAN_W-1:0]             chan_reg;
    logic [icsu_pkg::COEF_W-1:0]   coef_top_reg;
    logic [icsu_pkg::COEF_W-1:0]   coef_mid_reg;
    logic [icsu_pkg::COEF_W-1:0]   coef_bot_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= icsu_pkg::RST_IMAGE_WIDTH;
            height_reg   <= icsu_pkg::RST_IMAGE_HEIGHT;
            chan_reg     <= icsu_pkg::RST_CHANNEL_COUNT;
            coef_top_reg <= icsu_pkg::RST_COEF_TOP;
            coef_mid_reg <= icsu_pkg::RST_COEF_MID;
            coef_bot_reg <= icsu_pkg::RST_COEF_BOTTOM;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                icsu_pkg::REG_IMAGE_WIDTH:     width_reg    <= cfg.data[icsu_pkg::WIDTH_W-1:0];
                icsu_pkg::REG_IMAGE_HEIGHT:    height_reg   <= cfg.data[DIM_W-1:0];
                icsu_pkg::REG_CHANNEL_COUNT:   chan_reg     <= cfg.data[CHAN_W-1:0];
                icsu_pkg::REG_COEF_ROW_TOP:    coef_top_reg <= cfg.data;
                icsu_pkg::REG_COEF_ROW_MID:    coef_mid_reg <= cfg.data;
                icsu_pkg::REG_COEF_ROW_BOTTOM: coef_bot_reg <= cfg.data;
                default:                       ;
            endcase
        end
    end

    // effective geometry: zero width or height acts as one, oversize clamps
    logic [DIM_W-1:0]   w_wide;
    logic [WW-1:0]      eff_w;
    logic [DIM_W-1:0]   eff_h;
    logic [CHAN_W-1:0]  eff_c;

    always_comb
    begin
        if (width_reg == '0)
            w_wide = DIM_W'(1);
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
            w_wide = DIM_W'(MAX_WIDTH);
        else
            w_wide = DIM_W'(width_reg);

        if (height_reg == '0)
            eff_h = DIM_W'(1);
        else if (height_reg > icsu_pkg::MAX_HEIGHT)
            eff_h = icsu_pkg::MAX_HEIGHT;
        else
            eff_h = height_reg;

        if (chan_reg > CHAN_W'(MAX_CHANNELS))
            eff_c = CHAN_W'(MAX_CHANNELS);
        else
            eff_c = chan_reg;
    end

    assign eff_w = w_wide[WW-1:0];

    // kernel taps, row-major, left tap in low bits of each row
    logic signed [TAP_W-1:0] tap [TAPS];

    always_comb
    begin
        for (int c = 0; c < KSIZE; c++)
        begin
            tap[c]           = coef_top_reg[TAP_W*c +: TAP_W];
            tap[KSIZE + c]   = coef_mid_reg[TAP_W*c +: TAP_W];
            tap[2*KSIZE + c] = coef_bot_reg[TAP_W*c +: TAP_W];
        end
    end

    // ------------------------------------------------------------------
    // intake: position counters and item classification
    // ------------------------------------------------------------------
    logic [CW-1:0]      col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;

    logic               draining;
    logic               take;        // transfer on the pixel channel
    logic               proc;        // transfer that advances the frame
    logic               row_wrap;
    logic               emit;        // this item completes a result
    logic               interior;
    logic               last;
    logic [SW-1:0]      in_pix;
    logic [PIX_W-1:0]   in_byte [NUM_CH];

    assign in_byte[0] = pixel.in_ch0;
    assign in_byte[1] = pixel.in_ch1;
    assign in_byte[2] = pixel.in_ch2;
    assign in_byte[3] = pixel.in_ch3;

    assign draining = (row_reg >= eff_h);
    assign take     = pixel.valid && pixel.ready;
    // a drain tick while pixels are still due does nothing
    assign proc     = take && !((pixel.operation == icsu_pkg::OP_DRAIN) && !draining);

    always_comb
    begin
        // drain positions shift zeros through window and line stores
        in_pix = '0;
        if (!draining)
        begin
            for (int k = 0; k < MAX_CHANNELS; k++)
                in_pix[PIX_W*k +: PIX_W] = in_byte[k];
        end
    end

    assign row_wrap = (CNT_W'(col_reg) + CNT_W'(1)) >= CNT_W'(eff_w);
    assign emit     = (row_reg >= DIM_W'(2)) || ((row_reg == DIM_W'(1)) && (col_reg != '0));
    // the result is for the pixel one row up and one column left
    assign interior = (col_reg >= CW'(2))
                   && ((CNT_W'(col_reg) + CNT_W'(1)) <= CNT_W'(eff_w))
                   && (row_reg >= DIM_W'(2))
                   && ((ROWX_W'(row_reg) + ROWX_W'(1)) <= ROWX_W'(eff_h));
    assign last     = ROWX_W'(row_reg) >= (ROWX_W'(eff_h) + ROWX_W'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (proc)
        begin
            priority if (emit && last)
            begin
                // end of frame, start the next one
                col_next = '0;
                row_next = '0;
            end
            else if (row_wrap)
            begin
                col_next = '0;
                row_next = row_reg + DIM_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // line stores: read at intake, written back from stage 1 in the next cycle, never later
    // ------------------------------------------------------------------
    logic [SW-1:0]  upper_mem [MAX_WIDTH];
    logic [SW-1:0]  lower_mem [MAX_WIDTH];
    logic [SW-1:0]  up_rd_reg;
    logic [SW-1:0]  lo_rd_reg;

    // stage 1: item whose line-store data is arriving
    logic           s1_vld_reg;
    logic           s1_res_reg;
    logic           s1_int_reg;
    logic           s1_last_reg;
    logic [CW-1:0]  s1_idx_reg;
    logic [SW-1:0]  s1_pix_reg;

    // write-back from the previous item to the same column bypasses the read
    logic           fwd_hit_reg;
    logic [SW-1:0]  fwd_up_reg;
    logic [SW-1:0]  fwd_lo_reg;
    logic [SW-1:0]  up_fix;
    logic [SW-1:0]  lo_fix;

    assign up_fix = fwd_hit_reg ? fwd_up_reg : up_rd_reg;
    assign lo_fix = fwd_hit_reg ? fwd_lo_reg : lo_rd_reg;

    always_ff @(posedge clk)
    begin
        up_rd_reg <= upper_mem[col_reg];
        if (s1_vld_reg)
            upper_mem[s1_idx_reg] <= lo_fix;
    end

    always_ff @(posedge clk)
    begin
        lo_rd_reg <= lower_mem[col_reg];
        if (s1_vld_reg)
            lower_mem[s1_idx_reg] <= s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= proc;
            fwd_hit_reg <= s1_vld_reg && (s1_idx_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_res_reg  <= emit;
        s1_int_reg  <= interior;
        s1_last_reg <= last;
        s1_idx_reg  <= col_reg;
        s1_pix_reg  <= in_pix;
        fwd_up_reg  <= lo_fix;
        fwd_lo_reg  <= s1_pix_reg;
    end

    // ------------------------------------------------------------------
    // 3x3 window, shifted left by one column per item
    // ------------------------------------------------------------------
    logic [SW-1:0]  win_reg [TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TAPS; t++)
                win_reg[t] <= '0;
        end
        else if (s1_vld_reg)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                win_reg[r*KSIZE]     <= win_reg[r*KSIZE + 1];
                win_reg[r*KSIZE + 1] <= win_reg[r*KSIZE + 2];
            end
            win_reg[KSIZE - 1]       <= up_fix;
            win_reg[2*KSIZE - 1]     <= lo_fix;
            win_reg[TAPS - 1]        <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // result pipeline: multiply, row sums, final sum and clamp
    // ------------------------------------------------------------------
    logic           s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic           s2_int_reg, s3_int_reg, s4_int_reg;
    logic           s2_last_reg, s3_last_reg, s4_last_reg;
    logic [SW-1:0]  s3_ctr_reg, s4_ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg && s1_res_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_int_reg  <= s1_int_reg;
        s2_last_reg <= s1_last_reg;
        s3_int_reg  <= s2_int_reg;
        s3_last_reg <= s2_last_reg;
        s3_ctr_reg  <= win_reg[TAPS / 2];
        s4_int_reg  <= s3_int_reg;
        s4_last_reg <= s3_last_reg;
        s4_ctr_reg  <= s3_ctr_reg;
    end

    logic [PIX_W-1:0] filt_byte [NUM_CH];
    logic [PIX_W-1:0] ctr_byte  [NUM_CH];

    for (genvar k = 0; k < NUM_CH; k++)
    begin : g_lane
        if (k < MAX_CHANNELS)
        begin : g_used
            logic signed [PROD_W-1:0] prod_reg [TAPS];
            logic signed [RSUM_W-1:0] rsum_reg [KSIZE];
            logic signed [SUM_W-1:0]  total;

            always_ff @(posedge clk)
            begin
                for (int t = 0; t < TAPS; t++)
                    prod_reg[t] <= $signed({1'b0, win_reg[t][PIX_W*k +: PIX_W]}) * tap[t];
            end

            always_ff @(posedge clk)
            begin
                for (int r = 0; r < KSIZE; r++)
                    rsum_reg[r] <= RSUM_W'(prod_reg[r*KSIZE])
                                 + RSUM_W'(prod_reg[r*KSIZE + 1])
                                 + RSUM_W'(prod_reg[r*KSIZE + 2]);
            end

            assign total = SUM_W'(rsum_reg[0]) + SUM_W'(rsum_reg[1]) + SUM_W'(rsum_reg[2]);

            // sum is Q.8: negative clamps to 0, floor above 255 clamps to 255
            always_comb
            begin
                priority if (total[SUM_W-1])
                    filt_byte[k] = '0;
                else if (|total[SUM_W-2:2*PIX_W])
                    filt_byte[k] = '1;
                else
                    filt_byte[k] = total[2*PIX_W-1:PIX_W];
            end

            assign ctr_byte[k] = s4_ctr_reg[PIX_W*k +: PIX_W];
        end
        else
        begin : g_unused
            assign filt_byte[k] = '0;
            assign ctr_byte[k]  = '0;
        end
    end

    res_t push_res;

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            if (CHAN_W'(k) < eff_c)
                push_res.ch[k] = s4_int_reg ? filt_byte[k] : ctr_byte[k];
            else
                push_res.ch[k] = '0;
        end
        push_res.filtered = s4_int_reg;
        push_res.last     = s4_last_reg;
    end

    // ------------------------------------------------------------------
    // result queue and input credit
    // ------------------------------------------------------------------
    res_t               fifo_mem [FDEPTH];
    logic [FPTR_W-1:0]  wr_ptr_reg;
    logic [FPTR_W-1:0]  rd_ptr_reg;
    logic [FCNT_W-1:0]  fifo_cnt_reg;
    logic               push;
    logic               pop;
    logic [2:0]         inflight;
    res_t               head;

    assign push = s4_vld_reg;
    assign pop  = result.valid && result.ready;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FPTR_W'(1);
            unique case ({push, pop})
                2'b10:   fifo_cnt_reg <= fifo_cnt_reg + FCNT_W'(1);
                2'b01:   fifo_cnt_reg <= fifo_cnt_reg - FCNT_W'(1);
                default: fifo_cnt_reg <= fifo_cnt_reg;
            endcase
        end
    end

    // every possible result in flight holds a queue slot
    assign inflight = 3'(s1_vld_reg && s1_res_reg) + 3'(s2_vld_reg)
                    + 3'(s3_vld_reg) + 3'(s4_vld_reg);

    assign pixel.ready = (FCNT_W'(inflight) + fifo_cnt_reg) < FCNT_W'(FDEPTH);

    assign head                = fifo_mem[rd_ptr_reg];
    assign result.valid        = (fifo_cnt_reg != '0);
    assign result.out_ch0      = head.ch[0];
    assign result.out_ch1      = head.ch[1];
    assign result.out_ch2      = head.ch[2];
    assign result.out_ch3      = head.ch[3];
    assign result.was_filtered = head.filtered;
    assign result.frame_last   = head.last;

endmodule

`default_nettype wire
